/* design/fte_pkg.sv */
// Package for the function-reference table engine.
// Holds action and status codes, register indexes and the controller/datapath
// types. No dependencies.
`default_nettype none
package fte_pkg;

  localparam logic [2:0] ACT_GET  = 3'd0;
  localparam logic [2:0] ACT_SET  = 3'd1;
  localparam logic [2:0] ACT_SIZE = 3'd2;
  localparam logic [2:0] ACT_GROW = 3'd3;
  localparam logic [2:0] ACT_FILL = 3'd4;
  localparam logic [2:0] ACT_COPY = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TRAP     = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [2:0] CFG_FUNC_COUNT = 3'd0;
  localparam logic [2:0] CFG_T0_MAX     = 3'd1;
  localparam logic [2:0] CFG_T0_HAS_MAX = 3'd2;
  localparam logic [2:0] CFG_T1_MAX     = 3'd3;
  localparam logic [2:0] CFG_T1_HAS_MAX = 3'd4;

  typedef enum logic [1:0] {
    ROUTE_DONE,
    ROUTE_GET,
    ROUTE_FILL,
    ROUTE_COPY
  } route_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_FILL,
    S_CP_RD,
    S_CP_WR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic get_cap;
    logic fill_wr;
    logic cp_rd;
    logic cp_wr;
  } cmd_t;

  typedef struct packed {
    route_t route;
    logic   rem_last;
  } sts_t;

endpackage
`default_nettype wire

/* design/fte_ctrl.sv */
// Controller state machine for the function-reference table engine.
// Sequences get, fill/grow and copy steps. Depends on fte_pkg.
`default_nettype none
module fte_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  input  fte_pkg::sts_t    sts,
  output fte_pkg::cmd_t    cmd
);
  import fte_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (sts.route)
            ROUTE_GET:  state_nxt = S_GET;
            ROUTE_FILL: state_nxt = S_FILL;
            ROUTE_COPY: state_nxt = S_CP_RD;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_GET: begin
        cmd.get_cap = 1'b1;
        state_nxt   = S_OUT;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.rem_last) begin
          state_nxt = S_OUT;
        end
      end
      S_CP_RD: begin
        cmd.cp_rd = 1'b1;
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.cp_wr = 1'b1;
        state_nxt = sts.rem_last ? S_OUT : S_CP_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item accepted while result pending");
  a_get_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.route == ROUTE_GET) |=> state_r == S_GET)
    else $error("get did not enter read wait");
  a_copy_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CP_RD) |=> state_r == S_CP_WR)
    else $error("copy read not followed by write");

endmodule
`default_nettype wire

/* design/fte_datapath.sv */
// Datapath for the function-reference table engine: config registers,
// table sizes, entry memory, range checks and result registers. Uses fte_pkg.
`default_nettype none
module fte_datapath #(
  parameter int NUM_TABLES = 2,
  parameter int CAPACITY   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [2:0]  action,
  input  wire logic        table_sel,
  input  wire logic        source_table_sel,
  input  wire logic [31:0] dest_position,
  input  wire logic [31:0] src_position,
  input  wire logic [31:0] count,
  input  wire logic        value_is_funcref,
  input  wire logic        value_is_null,
  input  wire logic [31:0] value_function_index,
  input  fte_pkg::cmd_t    cmd,
  output fte_pkg::sts_t    sts,
  output logic [1:0]       status,
  output logic             entry_is_null,
  output logic [31:0]      entry_function_index,
  output logic [31:0]      size_or_previous
);
  import fte_pkg::*;

  localparam int DEPTH = NUM_TABLES * CAPACITY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW    = $clog2(CAPACITY + 1);

  logic [31:0] fcount_r, max0_r, max1_r;
  logic        hm0_r, hm1_r;
  logic [SW-1:0] tsize_r [NUM_TABLES];

  logic [32:0] mem [DEPTH];
  logic [32:0] rdata_r;

  logic          tsel_r, ssel_r, desc_r, grow_r;
  logic [PW-1:0] dptr_r, sptr_r;
  logic [SW-1:0] rem_r, gnext_r;
  logic [32:0]   val_r;
  logic [1:0]    status_r;
  logic          enull_r;
  logic [31:0]   eidx_r, sz_r;

  function automatic logic [AW-1:0] ent_addr(logic t, logic [PW-1:0] p);
    return AW'(t) * AW'(CAPACITY) + AW'(p);
  endfunction

  // request decode
  logic [SW-1:0] size_d, size_s;
  logic [31:0]   size32, ssize32, vidx, dstart;
  logic [32:0]   end_d, end_s, gnext;
  logic          t_ok, s_ok, fidx_bad, fits_d, fits_s, gfail, hm, desc, set_ok;
  logic [31:0]   maxv;
  logic [1:0]    st_n;
  logic [31:0]   sz_n;
  route_t        route_n;

  always_comb begin
    size_d = '0;
    size_s = '0;
    for (int i = 0; i < NUM_TABLES; i++) begin
      if (i == int'(table_sel)) size_d = tsize_r[i];
      if (i == int'(source_table_sel)) size_s = tsize_r[i];
    end
    size32   = 32'(size_d);
    ssize32  = 32'(size_s);
    t_ok     = (table_sel == 1'b0) || (NUM_TABLES > 1);
    s_ok     = (source_table_sel == 1'b0) || (NUM_TABLES > 1);
    vidx     = value_is_null ? '1 : value_function_index;
    fidx_bad = !value_is_null && (vidx >= fcount_r);
    end_d    = {1'b0, dest_position} + {1'b0, count};
    end_s    = {1'b0, src_position} + {1'b0, count};
    fits_d   = end_d <= {1'b0, size32};
    fits_s   = end_s <= {1'b0, ssize32};
    gnext    = {1'b0, size32} + {1'b0, count};
    hm       = table_sel ? hm1_r : hm0_r;
    maxv     = table_sel ? max1_r : max0_r;
    gfail    = gnext[32] || (hm && gnext > {1'b0, maxv}) || (gnext > 33'(CAPACITY));
    desc     = (action == ACT_COPY) && (dest_position > src_position);
    dstart   = desc ? dest_position + count - 32'd1 : dest_position;
    st_n     = ST_OK;
    sz_n     = '0;
    route_n  = ROUTE_DONE;
    set_ok   = 1'b0;
    if (!t_ok || (action == ACT_COPY && !s_ok)) begin
      st_n = ST_INVALID;
    end else begin
      case (action)
        ACT_GET: begin
          if (dest_position >= size32) st_n = ST_TRAP;
          else route_n = ROUTE_GET;
        end
        ACT_SET: begin
          if (!value_is_funcref) st_n = ST_MISMATCH;
          else if (dest_position >= size32) st_n = ST_TRAP;
          else if (fidx_bad) st_n = ST_INVALID;
          else set_ok = 1'b1;
        end
        ACT_SIZE: sz_n = size32;
        ACT_GROW: begin
          sz_n = size32;
          if (!value_is_funcref) st_n = ST_MISMATCH;
          else if (fidx_bad) st_n = ST_INVALID;
          else if (gfail) sz_n = '1;
          else if (count != '0) route_n = ROUTE_FILL;
        end
        ACT_FILL: begin
          if (!value_is_funcref) st_n = ST_MISMATCH;
          else if (!fits_d) st_n = ST_TRAP;
          else if (fidx_bad) st_n = ST_INVALID;
          else if (count != '0) route_n = ROUTE_FILL;
        end
        ACT_COPY: begin
          if (!(fits_d && fits_s)) st_n = ST_TRAP;
          else if (count != '0) route_n = ROUTE_COPY;
        end
        default: st_n = ST_INVALID;
      endcase
    end
  end

  assign sts.route    = route_n;
  assign sts.rem_last = (rem_r == SW'(1));

  // entry memory
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [32:0]   wr_data;

  always_comb begin
    wr_en   = (cmd.accept && set_ok) || cmd.fill_wr || cmd.cp_wr;
    wr_addr = cmd.accept ? ent_addr(table_sel, PW'(dest_position)) : ent_addr(tsel_r, dptr_r);
    wr_data = cmd.accept ? {value_is_null, vidx} : (cmd.fill_wr ? val_r : rdata_r);
    rd_en   = cmd.accept || cmd.cp_rd;
    rd_addr = cmd.cp_rd ? ent_addr(ssel_r, sptr_r) : ent_addr(table_sel, PW'(dest_position));
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // config and table sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= '0;
      max0_r   <= '0;
      hm0_r    <= 1'b0;
      max1_r   <= '0;
      hm1_r    <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) tsize_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FUNC_COUNT: fcount_r <= cfg_data;
          CFG_T0_MAX:     max0_r   <= cfg_data;
          CFG_T0_HAS_MAX: hm0_r    <= cfg_data[0];
          CFG_T1_MAX:     max1_r   <= cfg_data;
          CFG_T1_HAS_MAX: hm1_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.fill_wr && sts.rem_last && grow_r) begin
        for (int i = 0; i < NUM_TABLES; i++) begin
          if (i == int'(tsel_r)) tsize_r[i] <= gnext_r;
        end
      end
    end
  end

  // item state and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tsel_r   <= table_sel;
      ssel_r   <= source_table_sel;
      desc_r   <= desc;
      grow_r   <= (action == ACT_GROW);
      rem_r    <= SW'(count);
      gnext_r  <= SW'(gnext);
      val_r    <= {value_is_null, vidx};
      dptr_r   <= (action == ACT_GROW) ? PW'(size32) : PW'(dstart);
      sptr_r   <= desc ? PW'(src_position + count - 32'd1) : PW'(src_position);
      status_r <= st_n;
      sz_r     <= sz_n;
      enull_r  <= 1'b0;
      eidx_r   <= '0;
    end
    if (cmd.get_cap) begin
      enull_r <= rdata_r[32];
      eidx_r  <= rdata_r[31:0];
    end
    if (cmd.fill_wr) begin
      dptr_r <= dptr_r + PW'(1);
      rem_r  <= rem_r - SW'(1);
    end
    if (cmd.cp_wr) begin
      dptr_r <= desc_r ? dptr_r - PW'(1) : dptr_r + PW'(1);
      sptr_r <= desc_r ? sptr_r - PW'(1) : sptr_r + PW'(1);
      rem_r  <= rem_r - SW'(1);
    end
  end

  assign status               = status_r;
  assign entry_is_null        = enull_r;
  assign entry_function_index = eidx_r;
  assign size_or_previous     = sz_r;

endmodule
`default_nettype wire

/* design/funcref_table_engine.sv */
// Top level of the function-reference table engine.
// Joins fte_ctrl and fte_datapath; depends on fte_pkg.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | action .. value_function_index
//  out_    | output    | out_valid/out_stall| status .. size_or_previous
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time. Set and size go from S_IDLE to S_OUT; get passes S_GET,
// which captures the memory read. Fill and grow: one write per entry in S_FILL.
// Copy: a read (S_CP_RD) and a write (S_CP_WR) per entry on the entry memory.
// Result holds until out_stall drops; input stalls until then.
// Synchronous reset clears sizes and config; no memory clearing pass.
`default_nettype none
module funcref_table_engine #(
  parameter int NUM_TABLES = 2,
  parameter int CAPACITY   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic        in_table_sel,
  input  wire logic        in_source_table_sel,
  input  wire logic [31:0] in_dest_position,
  input  wire logic [31:0] in_src_position,
  input  wire logic [31:0] in_count,
  input  wire logic        in_value_is_funcref,
  input  wire logic        in_value_is_null,
  input  wire logic [31:0] in_value_function_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_entry_is_null,
  output logic [31:0]      out_entry_function_index,
  output logic [31:0]      out_size_or_previous
);
  import fte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fte_datapath #(
    .NUM_TABLES (NUM_TABLES),
    .CAPACITY   (CAPACITY)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .action               (in_action),
    .table_sel            (in_table_sel),
    .source_table_sel     (in_source_table_sel),
    .dest_position        (in_dest_position),
    .src_position         (in_src_position),
    .count                (in_count),
    .value_is_funcref     (in_value_is_funcref),
    .value_is_null        (in_value_is_null),
    .value_function_index (in_value_function_index),
    .cmd                  (cmd),
    .sts                  (sts),
    .status               (out_status),
    .entry_is_null        (out_entry_is_null),
    .entry_function_index (out_entry_function_index),
    .size_or_previous     (out_size_or_previous)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for funcref_table_engine: drives table requests and register
// writes, predicts each result in a scoreboard class. Depends on fte_pkg.
`timescale 1ns / 100ps
module tb_top;
  import fte_pkg::*;

  localparam int NTAB = 2;
  localparam int CAP  = 256;

  class table_scoreboard;
    logic [31:0] func_count;
    logic [31:0] max_size [NTAB];
    logic        has_max [NTAB];
    logic [31:0] tsize [NTAB];
    logic        ent_null [NTAB][CAP];
    logic [31:0] ent_idx [NTAB][CAP];
    logic [1:0]  exp_status [$];
    logic        exp_null [$];
    logic [31:0] exp_idx [$];
    logic [31:0] exp_size [$];
    int errors;

    function new();
      func_count = 0;
      errors = 0;
      for (int i = 0; i < NTAB; i++) begin
        max_size[i] = 0;
        has_max[i] = 0;
        tsize[i] = 0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_FUNC_COUNT: func_count = d;
        CFG_T0_MAX: max_size[0] = d;
        CFG_T0_HAS_MAX: has_max[0] = d[0];
        CFG_T1_MAX: max_size[1] = d;
        CFG_T1_HAS_MAX: has_max[1] = d[0];
        default: ;
      endcase
    endfunction

    function bit fits(logic [63:0] st, logic [63:0] len, logic [63:0] sz);
      return st <= sz && len <= sz - st;
    endfunction

    function void note_item(logic [2:0] act, logic t, logic s, logic [31:0] dpos,
                            logic [31:0] spos, logic [31:0] cnt, logic isref,
                            logic vnull, logic [31:0] vidx_in);
      logic [1:0] st;
      logic en;
      logic [31:0] ei, so, vidx;
      logic [63:0] nxt;
      logic tn [CAP];
      logic [31:0] ti [CAP];
      st = ST_OK; en = 0; ei = 0; so = 0;
      vidx = vnull ? 32'hFFFF_FFFF : vidx_in;
      case (act)
        ACT_GET: begin
          if (dpos >= tsize[t]) st = ST_TRAP;
          else begin
            en = ent_null[t][dpos]; ei = ent_idx[t][dpos];
          end
        end
        ACT_SET: begin
          if (!isref) st = ST_MISMATCH;
          else if (dpos >= tsize[t]) st = ST_TRAP;
          else if (!vnull && vidx >= func_count) st = ST_INVALID;
          if (st == ST_OK) begin
            ent_null[t][dpos] = vnull; ent_idx[t][dpos] = vidx;
          end
        end
        ACT_SIZE: so = tsize[t];
        ACT_GROW: begin
          so = tsize[t];
          nxt = 64'(tsize[t]) + 64'(cnt);
          if (!isref) st = ST_MISMATCH;
          else if (!vnull && vidx >= func_count) st = ST_INVALID;
          else if (nxt > 64'hFFFF_FFFF || (has_max[t] && nxt > 64'(max_size[t]))
                   || nxt > CAP) so = 32'hFFFF_FFFF;
          else begin
            for (int i = tsize[t]; i < nxt; i++) begin
              ent_null[t][i] = vnull; ent_idx[t][i] = vidx;
            end
            tsize[t] = nxt[31:0];
          end
        end
        ACT_FILL: begin
          if (!isref) st = ST_MISMATCH;
          else if (!fits(dpos, cnt, tsize[t])) st = ST_TRAP;
          else if (!vnull && vidx >= func_count) st = ST_INVALID;
          if (st == ST_OK)
            for (int i = 0; i < cnt; i++) begin
              ent_null[t][dpos + i] = vnull; ent_idx[t][dpos + i] = vidx;
            end
        end
        ACT_COPY: begin
          if (!fits(dpos, cnt, tsize[t]) || !fits(spos, cnt, tsize[s])) st = ST_TRAP;
          else begin
            for (int i = 0; i < cnt; i++) begin
              tn[i] = ent_null[s][spos + i]; ti[i] = ent_idx[s][spos + i];
            end
            for (int i = 0; i < cnt; i++) begin
              ent_null[t][dpos + i] = tn[i]; ent_idx[t][dpos + i] = ti[i];
            end
          end
        end
        default: st = ST_INVALID;
      endcase
      exp_status.push_back(st); exp_null.push_back(en);
      exp_idx.push_back(ei); exp_size.push_back(so);
    endfunction

    function void check_result(logic [1:0] st, logic en, logic [31:0] ei,
                               logic [31:0] so);
      logic [1:0] xs;
      logic xn;
      logic [31:0] xi, xz;
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, st);
        errors++;
        return;
      end
      xs = exp_status.pop_front(); xn = exp_null.pop_front();
      xi = exp_idx.pop_front(); xz = exp_size.pop_front();
      if (st !== xs) begin
        $display("%0t: status exp %0d got %0d", $time, xs, st); errors++;
      end
      if (en !== xn) begin
        $display("%0t: entry_is_null exp %0d got %0d", $time, xn, en); errors++;
      end
      if (ei !== xi) begin
        $display("%0t: entry_function_index exp %h got %h", $time, xi, ei); errors++;
      end
      if (so !== xz) begin
        $display("%0t: size_or_previous exp %h got %h", $time, xz, so); errors++;
      end
    endfunction

    function int pending();
      return exp_status.size();
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic [2:0] in_action = 0;
  logic in_table_sel = 0, in_source_table_sel = 0;
  logic [31:0] in_dest_position = 0, in_src_position = 0, in_count = 0;
  logic in_value_is_funcref = 0, in_value_is_null = 0;
  logic [31:0] in_value_function_index = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] out_status;
  logic out_entry_is_null;
  logic [31:0] out_entry_function_index, out_size_or_previous;

  int send_idle = 0, recv_idle = 0;
  table_scoreboard sb;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  funcref_table_engine uut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_entry_is_null, out_entry_function_index,
                      out_size_or_previous);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic send(logic [2:0] act, logic t, logic s, logic [31:0] dp,
                      logic [31:0] sp, logic [31:0] cnt, logic isref, logic vn,
                      logic [31:0] vi);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_action <= act; in_table_sel <= t;
    in_source_table_sel <= s; in_dest_position <= dp; in_src_position <= sp;
    in_count <= cnt; in_value_is_funcref <= isref; in_value_is_null <= vn;
    in_value_function_index <= vi;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, t, s, dp, sp, cnt, isref, vn, vi);
  endtask

  function automatic logic [31:0] pick_pos(logic [31:0] sz);
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return sz;
      default: return (sz == 0) ? 0 : $urandom_range(sz - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_cnt();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic random_items(int n);
    logic [2:0] act;
    logic t, s;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      t = $urandom; s = $urandom;
      if (act == ACT_GROW && sb.tsize[t] > 200 && $urandom_range(3) != 0) act = ACT_COPY;
      send(act, t, s, pick_pos(sb.tsize[t]), pick_pos(sb.tsize[s]),
           (act == ACT_GROW) ? (($urandom_range(7) == 0) ? $urandom : $urandom_range(20))
                             : pick_cnt(),
           $urandom_range(15) != 0, $urandom_range(3) == 0,
           ($urandom_range(7) == 0) ? $urandom : $urandom_range(sb.func_count + 2));
    end
    in_valid <= 0;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty tables, type and range errors, unknown actions
    send(ACT_GET, 0, 0, 0, 0, 0, 1, 0, 0);
    send(ACT_SIZE, 1, 0, 0, 0, 0, 1, 0, 0);
    send(ACT_GROW, 0, 0, 0, 0, 4, 1, 0, 0);
    send(ACT_GROW, 0, 0, 0, 0, 4, 0, 1, 0);
    send(ACT_GROW, 0, 0, 0, 0, 4, 1, 1, 32'hFFFF_FFFF);
    send(ACT_FILL, 0, 0, 4, 0, 0, 1, 1, 0);
    send(ACT_FILL, 0, 0, 5, 0, 0, 1, 1, 0);
    send(ACT_COPY, 0, 1, 0, 0, 0, 1, 0, 0);
    send(3'd6, 1, 1, 0, 0, 0, 1, 0, 0);
    send(3'd7, 0, 0, 0, 0, 0, 1, 0, 0);
    in_valid <= 0;
    drain();
    write_reg(CFG_FUNC_COUNT, 32'hFFFF_FFFF);
    write_reg(CFG_T0_MAX, 8);
    write_reg(CFG_T0_HAS_MAX, 1);
    write_reg(CFG_T1_MAX, 0);
    write_reg(CFG_T1_HAS_MAX, 0);
    send(ACT_GROW, 0, 0, 0, 0, 5, 1, 0, 32'hFFFF_FFFE);
    send(ACT_GROW, 1, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0);
    send(ACT_GROW, 1, 0, 0, 0, 257, 1, 1, 0);
    send(ACT_GROW, 1, 0, 0, 0, 256, 1, 0, 32'h5555_AAAA);
    send(ACT_SET, 0, 0, 1, 0, 0, 1, 0, 32'hFFFF_FFFF);
    send(ACT_SET, 0, 0, 2, 0, 0, 0, 0, 3);
    send(ACT_SET, 0, 0, 5, 0, 0, 1, 1, 3);
    send(ACT_SET, 0, 0, 0, 0, 0, 1, 1, 0);
    send(ACT_COPY, 0, 0, 1, 0, 4, 1, 0, 0);
    send(ACT_COPY, 1, 0, 250, 0, 5, 1, 0, 0);
    send(ACT_FILL, 0, 0, 32'hFFFF_FFFF, 0, 1, 1, 0, 0);
    for (int i = 0; i < 6; i++) send(ACT_GET, 0, 0, i, 0, 0, 1, 0, 0);
    in_valid <= 0;
    drain();
    write_reg(CFG_FUNC_COUNT, 10);
    write_reg(CFG_T0_HAS_MAX, 0);
    write_reg(CFG_T1_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_T1_HAS_MAX, 1);
    send_idle = 6; recv_idle = 72;
    random_items(180);
    drain();
    write_reg(CFG_FUNC_COUNT, 0);
    write_reg(CFG_T0_MAX, 32'hFFFF_FFFF);
    write_reg(CFG_T0_HAS_MAX, 1);
    write_reg(CFG_T1_MAX, 0);
    send_idle = 72; recv_idle = 6;
    random_items(180);
    drain();
    write_reg(CFG_FUNC_COUNT, 64);
    write_reg(CFG_T1_HAS_MAX, 0);
    send_idle = 0; recv_idle = 0;
    random_items(190);
    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* files.f */
design/fte_pkg.sv
design/fte_ctrl.sv
design/fte_datapath.sv
design/funcref_table_engine.sv
tb/tb_top.sv
